// File: rtl/core/mrbi_pkg.sv
package mrbi_pkg;

  localparam int ROWS         = 5;
  localparam int COLS         = 198;
  localparam int SAMPLE_WIDTH = 16;

  localparam int BLOCK_SIZE = ROWS * COLS;
  localparam int ADDR_W     = $clog2(BLOCK_SIZE);
  localparam int CNT_W      = $clog2(BLOCK_SIZE + 1);
  localparam int ACC_W      = $clog2(COLS + 1);
  localparam int COL_W      = $clog2(COLS);
  localparam int RSEL_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam int NUM_MULT  = 5;
  localparam int MULT_W    = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = CFG_IDX_W'(0);
  localparam int                   CFG_MULT_FIRST = 1;

  localparam logic [MULT_W-1:0] MULT_RESET [NUM_MULT] = '{
    MULT_W'(178), MULT_W'(164), MULT_W'(84), MULT_W'(14), MULT_W'(54)
  };

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic {
    DIR_INTERLEAVE   = 1'b0,
    DIR_DEINTERLEAVE = 1'b1
  } dir_e;

  typedef struct packed {
    logic step;
    logic clear;
  } addr_ctrl_t;

  // Reduce a multiplier modulo COLS+1 by restoring subtraction, one bit a step.
  function automatic logic [ACC_W-1:0] reduce_mult(input logic [MULT_W-1:0] m);
    logic [MULT_W-1:0] rem;
    rem = m;
    for (int i = MULT_W - 1; i >= 0; i--) begin
      if (int'(rem) >= ((COLS + 1) << i)) begin
        rem = rem - MULT_W'((COLS + 1) << i);
      end
    end
    return ACC_W'(rem);
  endfunction

endpackage

// File: rtl/core/mrbi_ram.sv
module mrbi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mrbi_addr_gen.sv
module mrbi_addr_gen
  import mrbi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  addr_ctrl_t        ctrl_i,
  input  logic [ACC_W-1:0]  mult_i [ROWS],
  output logic [ADDR_W-1:0] addr_o
);

  logic [ACC_W-1:0]  acc_q [ROWS];
  logic [RSEL_W-1:0] sel_q, sel_d;
  logic [ACC_W:0]    sum;
  logic [ACC_W-1:0]  acc_new;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] row_base;

  // Advance the selected row's accumulator modulo COLS+1.
  always_comb begin
    sum     = {1'b0, acc_q[sel_q]} + {1'b0, mult_i[sel_q]};
    acc_new = (sum >= (ACC_W + 1)'(COLS + 1)) ? ACC_W'(sum - (ACC_W + 1)'(COLS + 1))
                                             : ACC_W'(sum);
    col      = (acc_new == '0) ? COL_W'(COLS - 1) : COL_W'(acc_new - ACC_W'(1));
    row_base = ADDR_W'(sel_q * COLS);
    sel_d    = (sel_q == RSEL_W'(ROWS - 1)) ? '0 : sel_q + RSEL_W'(1);
  end

  assign addr_o = row_base + ADDR_W'(col);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ROWS; k++) acc_q[k] <= '0;
      sel_q <= '0;
    end else if (ctrl_i.clear) begin
      for (int k = 0; k < ROWS; k++) acc_q[k] <= '0;
      sel_q <= '0;
    end else if (ctrl_i.step) begin
      acc_q[sel_q] <= acc_new;
      sel_q        <= sel_d;
    end
  end

`ifndef SYNTHESIS
  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(sel_q) < ROWS)
    else $error("row select out of range");

  a_acc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.step && !ctrl_i.clear |=> int'($past(acc_new)) <= COLS)
    else $error("row accumulator left its modulus");
`endif

endmodule

// File: rtl/core/modular_row_block_interleaver_core.sv
// Block interleaver for turbo coding over ROWS x COLS samples (5 x 198). Loads (operation 0)
// fill the block; reads (operation 1) drain it once it is full, one result per read, and
// give not_ready with a zero sample while the block is still filling. Row k is permuted by
// position(i) = (mult_k*(i+1) mod (COLS+1)) - 1 and rows are visited column by column;
// direction 0 writes row-major and reads permuted, direction 1 writes permuted and reads
// row-major. A load into a full block is dropped. One transaction is taken every cycle while
// no read result is held back by a stalled output. A read result passes through the
// registered read port of the block memory, loaded on acceptance, then the output register,
// loaded unless the output is stalled. The block memory needs no clearing pass after reset.
// Write configuration only while the block is idle.
module modular_row_block_interleaver_core
  import mrbi_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,

  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [MULT_W-1:0]       cfg_data_i,

  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    operation_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,

  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SAMPLE_WIDTH-1:0] out_sample_o,
  output logic                    last_of_block_o,
  output logic                    not_ready_o
);

  dir_e               dir_q;
  logic [ACC_W-1:0]   mult_q [NUM_MULT];
  logic [ACC_W-1:0]   row_mult [ROWS];

  logic [CNT_W-1:0]   load_cnt_q, load_cnt_d;
  logic [ADDR_W-1:0]  read_cnt_q, read_cnt_d;

  logic               accept, is_read, full;
  logic               load_do, read_do, read_nr, load_last, read_last;
  addr_ctrl_t         addr_ctrl;
  logic [ADDR_W-1:0]  perm_addr;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;

  logic               s1_valid_q, s1_valid_d, s1_last_q, s1_nr_q, s1_move;
  logic               out_valid_q, out_valid_d;
  logic [SAMPLE_WIDTH-1:0] out_sample_q;
  logic               out_last_q, out_nr_q;

  // Configuration registers; multipliers are kept already reduced modulo COLS+1.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q <= DIR_INTERLEAVE;
      for (int k = 0; k < NUM_MULT; k++) mult_q[k] <= reduce_mult(MULT_RESET[k]);
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_DIRECTION) begin
        dir_q <= dir_e'(cfg_data_i[0]);
      end
      for (int k = 0; k < NUM_MULT; k++) begin
        if (cfg_index_i == CFG_IDX_W'(CFG_MULT_FIRST + k)) begin
          mult_q[k] <= reduce_mult(cfg_data_i);
        end
      end
    end
  end

  for (genvar k = 0; k < ROWS; k++) begin : g_row_mult
    if (k < NUM_MULT) begin : g_cfg
      assign row_mult[k] = mult_q[k];
    end else begin : g_one
      assign row_mult[k] = ACC_W'(1);
    end
  end

  // Hold the input while a read result waits behind a stalled output register.
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_read   = (op_e'(operation_i) == OP_READ);
  assign full      = (load_cnt_q == CNT_W'(BLOCK_SIZE));
  assign load_do   = accept && !is_read && !full;
  assign read_do   = accept && is_read && full;
  assign read_nr   = accept && is_read && !full;
  assign load_last = load_do && (load_cnt_q == CNT_W'(BLOCK_SIZE - 1));
  assign read_last = read_do && (read_cnt_q == ADDR_W'(BLOCK_SIZE - 1));

  assign addr_ctrl.step  = (load_do && dir_q == DIR_DEINTERLEAVE)
                        || (read_do && dir_q == DIR_INTERLEAVE);
  assign addr_ctrl.clear = load_last || read_last;

  mrbi_addr_gen u_addr_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (addr_ctrl),
    .mult_i (row_mult),
    .addr_o (perm_addr)
  );

  assign ram_waddr = (dir_q == DIR_DEINTERLEAVE) ? perm_addr : load_cnt_q[ADDR_W-1:0];
  assign ram_raddr = (dir_q == DIR_DEINTERLEAVE) ? read_cnt_q : perm_addr;

  mrbi_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (BLOCK_SIZE)
  ) u_block_ram (
    .clk_i   (clk_i),
    .we_i    (load_do),
    .waddr_i (ram_waddr),
    .wdata_i (sample_i),
    .re_i    (read_do),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    load_cnt_d = load_cnt_q;
    read_cnt_d = read_cnt_q;
    if (read_last) begin
      load_cnt_d = '0;
      read_cnt_d = '0;
    end else begin
      if (load_do) load_cnt_d = load_cnt_q + CNT_W'(1);
      if (read_do) read_cnt_d = read_cnt_q + ADDR_W'(1);
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept && is_read) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_move) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q  <= '0;
      read_cnt_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      load_cnt_q  <= load_cnt_d;
      read_cnt_q  <= read_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Flags travel alongside the memory read; data arrives from the RAM read register.
  always_ff @(posedge clk_i) begin
    if (accept && is_read) begin
      s1_last_q <= read_last;
      s1_nr_q   <= read_nr;
    end
    if (s1_move) begin
      out_sample_q <= s1_nr_q ? '0 : ram_rdata;
      out_last_q   <= s1_last_q;
      out_nr_q     <= s1_nr_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_sample_o    = out_sample_q;
  assign last_of_block_o = out_last_q;
  assign not_ready_o     = out_nr_q;

`ifndef SYNTHESIS
  a_load_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(load_cnt_q) <= BLOCK_SIZE)
    else $error("load count past block size");

  a_read_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_cnt_q != '0 |-> full)
    else $error("readout in progress on a block that is not full");

  a_block_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_last |=> load_cnt_q == '0 && read_cnt_q == '0)
    else $error("counters not cleared after the last read");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_move |=> s1_valid_q && $stable(s1_last_q) && $stable(s1_nr_q))
    else $error("pending read result lost while stalled");
`endif

endmodule
